>>> design/cpmc_pkg.sv
// ----------------------------------------------------------------------------
// cpmc_pkg: chiller PID mode controller shared definitions
// Widths, fixed point constants, codes and the command/status/result structs
// shared by the controller, the datapath and the channel interfaces.
// ----------------------------------------------------------------------------
package cpmc_pkg;

   // tuning
   localparam int PULSE_PERIOD     = 500;
   localparam int TICKS_PER_SECOND = 100;
   localparam int MIN_DRIVE        = 50;

   // field widths
   localparam int SAMPLE_W   = 16;
   localparam int TEMP_W     = 7;
   localparam int FAN_W      = 12;
   localparam int SPEED_W    = 7;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // internal widths
   localparam int FRAC_W      = 16;
   localparam int AVG_W       = 24;
   localparam int SUM_W       = 40;
   localparam int SUM_SPLIT   = 20;
   localparam int DRIVE_W     = 23;
   localparam int PULSE_W     = $clog2(PULSE_PERIOD + 2);
   localparam int TICK_W      = $clog2(TICKS_PER_SECOND + 1);
   localparam int OP_W        = 27;
   localparam int PROD_W      = 2 * OP_W;
   localparam int DELTA_SHIFT = 24;
   localparam int DELTA_W     = PROD_W - DELTA_SHIFT;

   // PID gains, Q0.24
   localparam int GAIN_P = 1174405;
   localparam int GAIN_I = 1678;
   localparam int GAIN_D = 83886;

   // divide by 10: bias keeps the dividend positive, offset removes it again
   localparam int SMOOTH_RECIP  = 53687092;
   localparam int SMOOTH_SHIFT  = 29;
   localparam int SMOOTH_OFFSET = 1 << 22;
   localparam int SMOOTH_BIAS   = 10 * SMOOTH_OFFSET + 5;

   localparam int ROUND_HALF = 1 << (DELTA_SHIFT - 1);
   localparam int DRIVE_MAX  = 100 << FRAC_W;
   localparam int DRIVE_LOW  = MIN_DRIVE << FRAC_W;
   localparam int FULL_SPEED = 100;

   // data types
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [TEMP_W-1:0]   temp_type;
   typedef logic        [FAN_W-1:0]    fan_type;
   typedef logic        [SPEED_W-1:0]  speed_type;
   typedef logic signed [OP_W-1:0]     op_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [AVG_W-1:0]    avg_type;
   typedef logic signed [AVG_W+1:0]    avg_wide_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic signed [SUM_W:0]      sum_wide_type;
   typedef logic        [DRIVE_W-1:0]  drive_type;
   typedef logic signed [DELTA_W:0]    drive_diff_type;
   typedef logic        [PULSE_W-1:0]  pulse_type;
   typedef logic        [PULSE_W:0]    pulse_wide_type;
   typedef logic        [TICK_W-1:0]   tick_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_OFF  = 2'd0,
      MODE_ON   = 2'd1,
      MODE_FAN  = 2'd2,
      MODE_COMP = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CIRC_TARGET  = 2'd0,
      CSR_STORE_HIGH   = 2'd1,
      CSR_STORE_LOW    = 2'd2,
      CSR_FAN_POST_RUN = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_STORE,
      ST_MUL_CIRC,
      ST_CIRC_AVG,
      ST_ERROR,
      ST_MUL_P,
      ST_MUL_D,
      ST_MUL_ILO,
      ST_MUL_IHI,
      ST_ACC_HI,
      ST_DRIVE,
      ST_PULSE,
      ST_COOL,
      ST_MODE
   } state_type;

   typedef enum logic [2:0] {
      MUL_STORE,
      MUL_CIRC,
      MUL_P,
      MUL_D,
      MUL_ILO,
      MUL_IHI,
      MUL_DRIVE
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_INIT,
      ACC_ADD,
      ACC_ADD_HI
   } acc_op_type;

   typedef enum logic [1:0] {
      COOL_HOLD,
      COOL_DIRECT,
      COOL_PULSE
   } cool_op_type;

   // controller -> datapath
   typedef struct packed {
      logic        load_in;
      mul_sel_type mul_sel;
      logic        store_upd;
      logic        circ_upd;
      logic        err_upd;
      logic        sum_upd;
      acc_op_type  acc_op;
      logic        prev_upd;
      logic        drive_upd;
      logic        pulse_upd;
      cool_op_type cool_op;
      logic        mode_upd;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic mode_off;
      logic drive_low;
   } status_type;

   // response payload
   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic                compressor_relay;
      logic                fan_relay;
      logic                pump_relay;
      logic [SPEED_W-1:0]  circulation_speed;
      logic [SPEED_W-1:0]  cooling_speed;
      logic [SAMPLE_W-1:0] store_smoothed;
      logic [SAMPLE_W-1:0] circ_smoothed;
      logic [FAN_W-1:0]    fan_seconds_left;
   } result_type;

endpackage

>>> design/cpmc_if.sv
// ----------------------------------------------------------------------------
// cpmc_if: channel interfaces of the chiller PID mode controller
// Request, response and register write channels, each with valid/ready.
// ----------------------------------------------------------------------------

// tick request channel
interface cpmc_req_if;
   logic                  valid;
   logic                  ready;
   cpmc_pkg::sample_type  store_sample;
   cpmc_pkg::sample_type  circ_sample;
   logic                  power_request;

   modport source (output valid, store_sample, circ_sample, power_request,
                   input ready);
   modport sink   (input valid, store_sample, circ_sample, power_request,
                   output ready);
endinterface

// result channel
interface cpmc_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [cpmc_pkg::MODE_W-1:0]           mode;
   logic                                  compressor_relay;
   logic                                  fan_relay;
   logic                                  pump_relay;
   logic [cpmc_pkg::SPEED_W-1:0]          circulation_speed;
   logic [cpmc_pkg::SPEED_W-1:0]          cooling_speed;
   cpmc_pkg::sample_type                  store_smoothed;
   cpmc_pkg::sample_type                  circ_smoothed;
   logic [cpmc_pkg::FAN_W-1:0]            fan_seconds_left;

   modport source (output valid, mode, compressor_relay, fan_relay, pump_relay,
                   circulation_speed, cooling_speed, store_smoothed,
                   circ_smoothed, fan_seconds_left,
                   input ready);
   modport sink   (input valid, mode, compressor_relay, fan_relay, pump_relay,
                   circulation_speed, cooling_speed, store_smoothed,
                   circ_smoothed, fan_seconds_left,
                   output ready);
endinterface

// register write channel
interface cpmc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [cpmc_pkg::CSR_IDX_W-1:0]    index;
   logic [cpmc_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/chiller_pid_mode_controller.sv
// ----------------------------------------------------------------------------
// A request transfer starts the smoothing states, then the PID states (the COOL
// state only below MIN_DRIVE) and the mode state, which waits for a free response
// slot; off mode skips the PID. One tick at a time; one shared 27x27 multiplier
// takes the two smoothing steps, the P, D and two I partial products and the slow
// pulse product in turn. Reset: synchronous, sets off mode with zeroed averages,
// error sum, previous error and drive, loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// chiller_pid_mode_controller: top level
// Chiller mode machine with smoothed temperatures, incremental PID cooling
// drive and slow pulse, built from a sequencer and a datapath.
// ----------------------------------------------------------------------------
module chiller_pid_mode_controller (
   input  logic        clock,
   input  logic        reset,
   cpmc_req_if.sink    req_chan,
   cpmc_rsp_if.source  rsp_chan,
   cpmc_csr_if.sink    csr_chan
);

   cpmc_pkg::cmd_type    cmd;
   cpmc_pkg::status_type status;
   cpmc_pkg::result_type result;

   // register writes always taken
   assign csr_chan.ready = 1'b1;

   cpmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cpmc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_write     (csr_chan.valid),
      .csr_index     (csr_chan.index),
      .csr_data      (csr_chan.data),
      .store_sample  (req_chan.store_sample),
      .circ_sample   (req_chan.circ_sample),
      .power_request (req_chan.power_request),
      .result        (result)
   );

   // result payload
   assign rsp_chan.mode              = result.mode;
   assign rsp_chan.compressor_relay  = result.compressor_relay;
   assign rsp_chan.fan_relay         = result.fan_relay;
   assign rsp_chan.pump_relay        = result.pump_relay;
   assign rsp_chan.circulation_speed = result.circulation_speed;
   assign rsp_chan.cooling_speed     = result.cooling_speed;
   assign rsp_chan.store_smoothed    = result.store_smoothed;
   assign rsp_chan.circ_smoothed     = result.circ_smoothed;
   assign rsp_chan.fan_seconds_left  = result.fan_seconds_left;

   // one tick in flight: no request right after a request transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while a tick is in flight");

   // relays follow the reported mode
   a_relays: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         (rsp_chan.compressor_relay == (rsp_chan.mode == cpmc_pkg::MODE_COMP)) &&
         (rsp_chan.pump_relay == (rsp_chan.mode != cpmc_pkg::MODE_OFF)) &&
         (rsp_chan.fan_relay == (rsp_chan.mode == cpmc_pkg::MODE_COMP ||
                                 rsp_chan.mode == cpmc_pkg::MODE_FAN)))
      else $error("relay drive does not match mode");

   // off mode never reports cooling
   a_off_no_cooling: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.mode == cpmc_pkg::MODE_OFF) |->
         rsp_chan.cooling_speed == '0)
      else $error("cooling speed nonzero in off mode");

   // cooling speed stays within percent range
   a_cool_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.cooling_speed <= 7'd100)
      else $error("cooling speed above 100");

endmodule

>>> design/cpmc_ctrl.sv
// ----------------------------------------------------------------------------
// cpmc_ctrl: sequencer of the chiller PID mode controller
// Steps one tick through smoothing, PID, slow pulse and mode update (off mode skips
// the PID), at most one multiplier operation per state, and owns the handshakes.
// ----------------------------------------------------------------------------
module cpmc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  cpmc_pkg::status_type status,
   output cpmc_pkg::cmd_type    cmd
);

   cpmc_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   // response slot can take a new result
   assign out_free = !rsp_valid_ff || rsp_ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpmc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cpmc_pkg::ST_IDLE: begin
            if (req_valid) state_in = cpmc_pkg::ST_MUL_STORE;
         end
         cpmc_pkg::ST_MUL_STORE: state_in = cpmc_pkg::ST_MUL_CIRC;
         cpmc_pkg::ST_MUL_CIRC:  state_in = cpmc_pkg::ST_CIRC_AVG;
         cpmc_pkg::ST_CIRC_AVG: begin
            // off mode skips the PID
            state_in = status.mode_off ? cpmc_pkg::ST_MODE : cpmc_pkg::ST_ERROR;
         end
         cpmc_pkg::ST_ERROR:   state_in = cpmc_pkg::ST_MUL_P;
         cpmc_pkg::ST_MUL_P:   state_in = cpmc_pkg::ST_MUL_D;
         cpmc_pkg::ST_MUL_D:   state_in = cpmc_pkg::ST_MUL_ILO;
         cpmc_pkg::ST_MUL_ILO: state_in = cpmc_pkg::ST_MUL_IHI;
         cpmc_pkg::ST_MUL_IHI: state_in = cpmc_pkg::ST_ACC_HI;
         cpmc_pkg::ST_ACC_HI:  state_in = cpmc_pkg::ST_DRIVE;
         cpmc_pkg::ST_DRIVE:   state_in = cpmc_pkg::ST_PULSE;
         cpmc_pkg::ST_PULSE: begin
            state_in = status.drive_low ? cpmc_pkg::ST_COOL : cpmc_pkg::ST_MODE;
         end
         cpmc_pkg::ST_COOL: state_in = cpmc_pkg::ST_MODE;
         cpmc_pkg::ST_MODE: begin
            if (out_free) state_in = cpmc_pkg::ST_IDLE;
         end
         default: state_in = cpmc_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath commands
   always_comb begin
      cmd           = '0;
      cmd.mul_sel   = cpmc_pkg::MUL_STORE;
      cmd.acc_op    = cpmc_pkg::ACC_HOLD;
      cmd.cool_op   = cpmc_pkg::COOL_HOLD;
      req_ready     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         cpmc_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         cpmc_pkg::ST_MUL_STORE: cmd.mul_sel = cpmc_pkg::MUL_STORE;
         cpmc_pkg::ST_MUL_CIRC: begin
            cmd.mul_sel   = cpmc_pkg::MUL_CIRC;
            cmd.store_upd = 1'b1;
         end
         cpmc_pkg::ST_CIRC_AVG: cmd.circ_upd = 1'b1;
         cpmc_pkg::ST_ERROR:    cmd.err_upd  = 1'b1;
         cpmc_pkg::ST_MUL_P: begin
            cmd.mul_sel = cpmc_pkg::MUL_P;
            cmd.sum_upd = 1'b1;
         end
         cpmc_pkg::ST_MUL_D: begin
            cmd.mul_sel  = cpmc_pkg::MUL_D;
            cmd.acc_op   = cpmc_pkg::ACC_INIT;
            cmd.prev_upd = 1'b1;
         end
         cpmc_pkg::ST_MUL_ILO: begin
            cmd.mul_sel = cpmc_pkg::MUL_ILO;
            cmd.acc_op  = cpmc_pkg::ACC_ADD;
         end
         cpmc_pkg::ST_MUL_IHI: begin
            cmd.mul_sel = cpmc_pkg::MUL_IHI;
            cmd.acc_op  = cpmc_pkg::ACC_ADD;
         end
         cpmc_pkg::ST_ACC_HI: cmd.acc_op    = cpmc_pkg::ACC_ADD_HI;
         cpmc_pkg::ST_DRIVE:  cmd.drive_upd = 1'b1;
         cpmc_pkg::ST_PULSE: begin
            cmd.mul_sel   = cpmc_pkg::MUL_DRIVE;
            cmd.pulse_upd = status.drive_low;
            cmd.cool_op   = status.drive_low ? cpmc_pkg::COOL_HOLD
                                             : cpmc_pkg::COOL_DIRECT;
         end
         cpmc_pkg::ST_COOL: cmd.cool_op = cpmc_pkg::COOL_PULSE;
         cpmc_pkg::ST_MODE: begin
            cmd.mode_upd = out_free;
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: cmd.load_in = 1'b0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> design/cpmc_datapath.sv
// ----------------------------------------------------------------------------
// cpmc_datapath: arithmetic and state of the chiller PID mode controller
// Shared 27x27 multiplier for smoothing, PID terms and slow pulse, accumulator for PID terms,
// controller state, slow pulse, mode cascade, registers and result register.
// ----------------------------------------------------------------------------
module cpmc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  cpmc_pkg::cmd_type                  cmd,
   output cpmc_pkg::status_type               status,
   input  logic                               csr_write,
   input  logic [cpmc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cpmc_pkg::CSR_DATA_W-1:0]    csr_data,
   input  cpmc_pkg::sample_type               store_sample,
   input  cpmc_pkg::sample_type               circ_sample,
   input  logic                               power_request,
   output cpmc_pkg::result_type               result
);

   // saturate a 26 bit value to the 24 bit average range
   function automatic cpmc_pkg::avg_type sat_avg(input cpmc_pkg::avg_wide_type x);
      cpmc_pkg::avg_type r;
      if ((x[cpmc_pkg::AVG_W+1] != x[cpmc_pkg::AVG_W]) ||
          (x[cpmc_pkg::AVG_W] != x[cpmc_pkg::AVG_W-1]))
         r = x[cpmc_pkg::AVG_W+1] ? {1'b1, {(cpmc_pkg::AVG_W-1){1'b0}}}
                                  : {1'b0, {(cpmc_pkg::AVG_W-1){1'b1}}};
      else
         r = x[cpmc_pkg::AVG_W-1:0];
      return r;
   endfunction

   // saturate a 41 bit value to the 40 bit error sum range
   function automatic cpmc_pkg::sum_type sat_sum(input cpmc_pkg::sum_wide_type x);
      cpmc_pkg::sum_type r;
      if (x[cpmc_pkg::SUM_W] != x[cpmc_pkg::SUM_W-1])
         r = x[cpmc_pkg::SUM_W] ? {1'b1, {(cpmc_pkg::SUM_W-1){1'b0}}}
                                : {1'b0, {(cpmc_pkg::SUM_W-1){1'b1}}};
      else
         r = x[cpmc_pkg::SUM_W-1:0];
      return r;
   endfunction

   // biased dividend of the 0.1 step: sample*256 - avg + SMOOTH_BIAS, kept positive
   function automatic cpmc_pkg::op_type smooth_operand(input cpmc_pkg::sample_type s,
                                                       input cpmc_pkg::avg_type avg);
      return cpmc_pkg::op_type'($signed({s, 8'h00})) - cpmc_pkg::op_type'(avg)
             + cpmc_pkg::op_type'(cpmc_pkg::SMOOTH_BIAS);
   endfunction

   // new average from the reciprocal product
   function automatic cpmc_pkg::avg_type smooth_next(input cpmc_pkg::prod_type p,
                                                     input cpmc_pkg::avg_type avg);
      cpmc_pkg::avg_wide_type q;
      q = cpmc_pkg::avg_wide_type'(
             $signed({1'b0, p[cpmc_pkg::SMOOTH_SHIFT+cpmc_pkg::AVG_W-2:
                              cpmc_pkg::SMOOTH_SHIFT]}));
      return sat_avg(cpmc_pkg::avg_wide_type'(avg) + q
                     - cpmc_pkg::avg_wide_type'(cpmc_pkg::SMOOTH_OFFSET));
   endfunction

   // registers
   cpmc_pkg::temp_type   tgt_ff, tgt_in, high_ff, high_in, low_ff, low_in;
   cpmc_pkg::fan_type    post_ff, post_in;
   cpmc_pkg::mode_type   mode_ff, mode_in;
   cpmc_pkg::avg_type    store_avg_ff, store_avg_in, circ_avg_ff, circ_avg_in;
   cpmc_pkg::sum_type    total_ff, total_in;
   cpmc_pkg::avg_type    prev_ff, prev_in, err_ff, err_in;
   cpmc_pkg::drive_type  drive_ff, drive_in;
   cpmc_pkg::pulse_type  pulse_ff, pulse_in;
   cpmc_pkg::tick_type   tick_ff, tick_in;
   cpmc_pkg::fan_type    fan_ff, fan_in;
   cpmc_pkg::speed_type  cool_ff, cool_in;
   cpmc_pkg::sample_type ss_ff, ss_in, cs_ff, cs_in;
   logic                 pwr_ff, pwr_in;
   cpmc_pkg::prod_type   prod_ff, prod_in, acc_ff, acc_in;
   cpmc_pkg::result_type result_ff, result_in;

   // combinational helpers
   cpmc_pkg::op_type         op_a, op_b;
   cpmc_pkg::drive_diff_type drive_diff;
   cpmc_pkg::pulse_wide_type pulse_next1;
   logic [cpmc_pkg::PROD_W-1:0] pulse_lhs;
   cpmc_pkg::mode_type       mode_c;
   cpmc_pkg::fan_type        fan_c;
   cpmc_pkg::tick_type       tick_c, tick_inc;
   cpmc_pkg::speed_type      cool_c;
   cpmc_pkg::avg_type        high_ext, low_ext;

   // multiplier operand select
   always_comb begin
      op_a = smooth_operand(ss_ff, store_avg_ff);
      op_b = cpmc_pkg::op_type'(cpmc_pkg::SMOOTH_RECIP);
      case (cmd.mul_sel)
         cpmc_pkg::MUL_STORE: op_a = smooth_operand(ss_ff, store_avg_ff);
         cpmc_pkg::MUL_CIRC:  op_a = smooth_operand(cs_ff, circ_avg_ff);
         cpmc_pkg::MUL_P: begin
            op_a = cpmc_pkg::op_type'(err_ff);
            op_b = cpmc_pkg::op_type'(cpmc_pkg::GAIN_P);
         end
         cpmc_pkg::MUL_D: begin
            op_a = cpmc_pkg::op_type'(err_ff) - cpmc_pkg::op_type'(prev_ff);
            op_b = cpmc_pkg::op_type'(cpmc_pkg::GAIN_D);
         end
         cpmc_pkg::MUL_ILO: begin
            op_a = cpmc_pkg::op_type'($signed({1'b0, total_ff[cpmc_pkg::SUM_SPLIT-1:0]}));
            op_b = cpmc_pkg::op_type'(cpmc_pkg::GAIN_I);
         end
         cpmc_pkg::MUL_IHI: begin
            op_a = cpmc_pkg::op_type'($signed(total_ff[cpmc_pkg::SUM_W-1:
                                                        cpmc_pkg::SUM_SPLIT]));
            op_b = cpmc_pkg::op_type'(cpmc_pkg::GAIN_I);
         end
         cpmc_pkg::MUL_DRIVE: begin
            op_a = cpmc_pkg::op_type'($signed({1'b0, drive_ff}));
            op_b = cpmc_pkg::op_type'(cpmc_pkg::PULSE_PERIOD);
         end
         default: op_b = cpmc_pkg::op_type'(cpmc_pkg::SMOOTH_RECIP);
      endcase
   end

   assign prod_in = cpmc_pkg::prod_type'(op_a) * cpmc_pkg::prod_type'(op_b);

   // drive minus rounded delta, before clamping
   assign drive_diff = cpmc_pkg::drive_diff_type'($signed({1'b0, drive_ff}))
      - cpmc_pkg::drive_diff_type'($signed(acc_ff[cpmc_pkg::PROD_W-1:
                                                  cpmc_pkg::DELTA_SHIFT]));

   // slow pulse: count < floor(PERIOD*drive/(MIN*2^16)) <=> (count+1)*MIN*2^16 <= PERIOD*drive
   assign pulse_next1 = cpmc_pkg::pulse_wide_type'(pulse_ff) + 1'b1;
   assign pulse_lhs   = (cpmc_pkg::PROD_W'(pulse_next1) * cpmc_pkg::PROD_W'(cpmc_pkg::MIN_DRIVE))
                        << cpmc_pkg::FRAC_W;

   // store limits in Q8.16
   assign high_ext = cpmc_pkg::avg_type'($signed({high_ff, {cpmc_pkg::FRAC_W{1'b0}}}));
   assign low_ext  = cpmc_pkg::avg_type'($signed({low_ff, {cpmc_pkg::FRAC_W{1'b0}}}));

   // mode cascade: off -> on -> compressor -> fan -> on, on -> off without power, all in one tick
   always_comb begin
      mode_c   = mode_ff;
      fan_c    = fan_ff;
      tick_c   = tick_ff;
      cool_c   = cool_ff;
      tick_inc = tick_ff + 1'b1;
      if (mode_c == cpmc_pkg::MODE_OFF && pwr_ff) mode_c = cpmc_pkg::MODE_ON;
      if (mode_c == cpmc_pkg::MODE_ON) begin
         if (!pwr_ff) begin
            mode_c = cpmc_pkg::MODE_OFF;
            cool_c = '0;
         end else if (store_avg_ff > high_ext) begin
            mode_c = cpmc_pkg::MODE_COMP;
         end
      end
      if (mode_c == cpmc_pkg::MODE_COMP) begin
         if (store_avg_ff < low_ext || !pwr_ff) begin
            mode_c = cpmc_pkg::MODE_FAN;
            fan_c  = post_ff;
            tick_c = '0;
         end
      end
      if (mode_c == cpmc_pkg::MODE_FAN) begin
         tick_inc = tick_c + 1'b1;
         if (tick_inc >= cpmc_pkg::tick_type'(cpmc_pkg::TICKS_PER_SECOND)) begin
            tick_c = '0;
            if (fan_c != '0) fan_c = fan_c - 1'b1;
            if (fan_c == '0) mode_c = cpmc_pkg::MODE_ON;
         end else begin
            tick_c = tick_inc;
         end
      end
   end

   // next values
   always_comb begin
      tgt_in       = tgt_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      post_in      = post_ff;
      mode_in      = mode_ff;
      store_avg_in = store_avg_ff;
      circ_avg_in  = circ_avg_ff;
      total_in     = total_ff;
      prev_in      = prev_ff;
      err_in       = err_ff;
      drive_in     = drive_ff;
      pulse_in     = pulse_ff;
      tick_in      = tick_ff;
      fan_in       = fan_ff;
      cool_in      = cool_ff;
      ss_in        = ss_ff;
      cs_in        = cs_ff;
      pwr_in       = pwr_ff;
      acc_in       = acc_ff;
      result_in    = result_ff;

      // register writes
      if (csr_write) begin
         case (cpmc_pkg::csr_index_type'(csr_index))
            cpmc_pkg::CSR_CIRC_TARGET:  tgt_in  = csr_data[cpmc_pkg::TEMP_W-1:0];
            cpmc_pkg::CSR_STORE_HIGH:   high_in = csr_data[cpmc_pkg::TEMP_W-1:0];
            cpmc_pkg::CSR_STORE_LOW:    low_in  = csr_data[cpmc_pkg::TEMP_W-1:0];
            cpmc_pkg::CSR_FAN_POST_RUN: post_in = csr_data[cpmc_pkg::FAN_W-1:0];
            default:                    post_in = post_ff;
         endcase
      end

      // input capture
      if (cmd.load_in) begin
         ss_in  = store_sample;
         cs_in  = circ_sample;
         pwr_in = power_request;
      end

      // smoothing
      if (cmd.store_upd) store_avg_in = smooth_next(prod_ff, store_avg_ff);
      if (cmd.circ_upd)  circ_avg_in  = smooth_next(prod_ff, circ_avg_ff);

      // PID error terms
      if (cmd.err_upd)
         err_in = sat_avg(cpmc_pkg::avg_wide_type'(circ_avg_ff)
                  - cpmc_pkg::avg_wide_type'($signed({tgt_ff,
                                                      {cpmc_pkg::FRAC_W{1'b0}}})));
      if (cmd.sum_upd)
         total_in = sat_sum(cpmc_pkg::sum_wide_type'(total_ff)
                            + cpmc_pkg::sum_wide_type'(err_ff));
      if (cmd.prev_upd) prev_in = err_ff;

      // accumulator of the PID products
      case (cmd.acc_op)
         cpmc_pkg::ACC_INIT:   acc_in = prod_ff + cpmc_pkg::prod_type'(cpmc_pkg::ROUND_HALF);
         cpmc_pkg::ACC_ADD:    acc_in = acc_ff + prod_ff;
         cpmc_pkg::ACC_ADD_HI: acc_in = acc_ff + (prod_ff <<< cpmc_pkg::SUM_SPLIT);
         default:              acc_in = acc_ff;
      endcase

      // drive clamp to 0..100
      if (cmd.drive_upd) begin
         if (drive_diff < 0)
            drive_in = '0;
         else if (drive_diff > cpmc_pkg::drive_diff_type'(cpmc_pkg::DRIVE_MAX))
            drive_in = cpmc_pkg::drive_type'(cpmc_pkg::DRIVE_MAX);
         else
            drive_in = drive_diff[cpmc_pkg::DRIVE_W-1:0];
      end

      // slow pulse counter wraps after PULSE_PERIOD+1
      if (cmd.pulse_upd)
         pulse_in = (pulse_ff > cpmc_pkg::pulse_type'(cpmc_pkg::PULSE_PERIOD))
                    ? '0 : pulse_next1[cpmc_pkg::PULSE_W-1:0];

      case (cmd.cool_op)
         cpmc_pkg::COOL_DIRECT:
            cool_in = drive_ff[cpmc_pkg::FRAC_W+cpmc_pkg::SPEED_W-1:cpmc_pkg::FRAC_W];
         cpmc_pkg::COOL_PULSE:
            cool_in = ($signed(pulse_lhs) <= prod_ff)
                      ? cpmc_pkg::speed_type'(cpmc_pkg::MIN_DRIVE) : '0;
         default: cool_in = cool_ff;
      endcase

      // mode update and result load
      if (cmd.mode_upd) begin
         mode_in = mode_c;
         fan_in  = fan_c;
         tick_in = tick_c;
         cool_in = cool_c;
         result_in.mode              = mode_c;
         result_in.compressor_relay  = (mode_c == cpmc_pkg::MODE_COMP);
         result_in.fan_relay         = (mode_c == cpmc_pkg::MODE_COMP) ||
                                       (mode_c == cpmc_pkg::MODE_FAN);
         result_in.pump_relay        = (mode_c != cpmc_pkg::MODE_OFF);
         result_in.circulation_speed = (mode_c != cpmc_pkg::MODE_OFF)
                                       ? cpmc_pkg::speed_type'(cpmc_pkg::FULL_SPEED) : '0;
         result_in.cooling_speed     = cool_c;
         result_in.store_smoothed    = store_avg_ff[cpmc_pkg::AVG_W-1:8];
         result_in.circ_smoothed     = circ_avg_ff[cpmc_pkg::AVG_W-1:8];
         result_in.fan_seconds_left  = fan_c;
      end
   end

   // controller state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff       <= 7'sd15;
         high_ff      <= 7'sd10;
         low_ff       <= 7'sd5;
         post_ff      <= 12'd60;
         mode_ff      <= cpmc_pkg::MODE_OFF;
         store_avg_ff <= '0;
         circ_avg_ff  <= '0;
         total_ff     <= '0;
         prev_ff      <= '0;
         drive_ff     <= '0;
         pulse_ff     <= '0;
         tick_ff      <= '0;
         fan_ff       <= '0;
         cool_ff      <= '0;
      end else begin
         tgt_ff       <= tgt_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         post_ff      <= post_in;
         mode_ff      <= mode_in;
         store_avg_ff <= store_avg_in;
         circ_avg_ff  <= circ_avg_in;
         total_ff     <= total_in;
         prev_ff      <= prev_in;
         drive_ff     <= drive_in;
         pulse_ff     <= pulse_in;
         tick_ff      <= tick_in;
         fan_ff       <= fan_in;
         cool_ff      <= cool_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      ss_ff     <= ss_in;
      cs_ff     <= cs_in;
      pwr_ff    <= pwr_in;
      err_ff    <= err_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

   assign status.mode_off  = (mode_ff == cpmc_pkg::MODE_OFF);
   assign status.drive_low = (drive_ff < cpmc_pkg::drive_type'(cpmc_pkg::DRIVE_LOW));
   assign result           = result_ff;

endmodule
